/* rtl/tdct_pkg.sv */
// ============================================================================
// tdct_pkg: shared types and constants of the character tokenizer
// Token kinds, scan states, result item layout, keyword list and queue sizing.
// ============================================================================
`default_nettype none

package tdct_pkg;

   localparam int unsigned CHAR_W         = 8;
   localparam int unsigned KIND_W         = 3;
   localparam int unsigned LEN_W          = 8;
   localparam int unsigned LEN_MAX        = 255;

   // Token counter saturates here; the reported length is then clipped to LEN_MAX.
   localparam int unsigned MAX_TOKEN_LEN  = 255;
   localparam int unsigned CNT_W          = $clog2(MAX_TOKEN_LEN + 1);

   // Leading characters of the open token kept for keyword matching.
   localparam int unsigned WORD_BUF_DEPTH = 8;
   localparam int unsigned WBI_W          = $clog2(WORD_BUF_DEPTH);

   // Result queue
   localparam int unsigned RQ_DEPTH       = 4;
   localparam int unsigned RQ_PTR_W       = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CNT_W       = $clog2(RQ_DEPTH + 1);

   // Keyword list; text is right-aligned, first character in the highest used byte.
   localparam int unsigned KW_NUM         = 12;
   localparam int unsigned KW_MAX_LEN     = 8;
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_NUM] = '{
      "int", "float", "bool", "if", "else", "then",
      "do", "while", "for", "and", "or", "function"};
   localparam logic [3:0] KW_LEN [KW_NUM] = '{
      4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd4, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd8};

   typedef enum logic [3:0] {
      S_IDLE  = 4'd0,
      S_INT   = 4'd1,
      S_REAL  = 4'd2,
      S_OP    = 4'd3,
      S_WORD  = 4'd4,
      S_SPACE = 4'd5,
      S_SEP   = 4'd6,
      S_CMT   = 4'd7,
      S_UNK   = 4'd8
   } scan_state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INT   = 3'd0,
      KIND_REAL  = 3'd1,
      KIND_OP    = 3'd2,
      KIND_KW    = 3'd3,
      KIND_ID    = 3'd4,
      KIND_SEP   = 3'd5,
      KIND_UNK   = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [LEN_W-1:0]   length;
      logic               last;
   } result_type;

   // Up to two results produced by one input item; res0 is always the first.
   typedef struct packed {
      logic [1:0]  num;
      result_type  res0;
      result_type  res1;
   } scan_out_type;

endpackage

`default_nettype wire

/* rtl/table_driven_char_tokenizer_unit.sv */
// ============================================================================
// table_driven_char_tokenizer_unit: table-driven character tokenizer
// One character per item in, token kind and length per result item out.
// ============================================================================
// Characters enter one item per clock into an input register while
// req_ready is high. Once the result queue has room, the scanner classifies
// the character, steps the nine-state table, updates the comment flag, token
// counter and eight-byte word buffer, and writes zero, one or two results
// into a four-entry result queue; rsp_ is driven from that registered queue.
// Throughput is one item per clock whenever each item yields at most one
// result and rsp_ready stays high; the registered update of the scan state,
// counter and word buffer, which feeds the next item's step, is the loop that
// sets this rate. An item that ends one token, opens another and closes the
// line yields two results, which leave the result port in turn. The scanner
// only runs when the queue has room for two results, so stalls on rsp_ back
// up into req_ready. rsp_last_of_run marks the final result of each item;
// items with no result (spaces, comments, open tokens) produce nothing on
// rsp_. Reported lengths saturate at 255.
// ============================================================================
`default_nettype none

module table_driven_char_tokenizer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tdct_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic                          req_line_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tdct_pkg::KIND_W-1:0]        rsp_token_kind,
   output logic [tdct_pkg::LEN_W-1:0]         rsp_token_length,
   output logic                               rsp_last_of_run
);
   import tdct_pkg::*;

   logic                 in_valid_ff;
   logic [CHAR_W-1:0]    in_char_ff;
   logic                 in_eol_ff;
   logic                 room, fire;
   scan_out_type         scan_out;
   result_type           head;

   // item in the input register moves on once the queue can take two results
   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_eol_ff  <= req_line_end;
      end
   end

   tdct_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .char_code (in_char_ff),
      .line_end  (in_eol_ff),
      .scan_out  (scan_out)
   );

   tdct_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_data  (scan_out),
      .room       (room),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready),
      .head       (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

endmodule

`default_nettype wire

/* rtl/tdct_kw_match.sv */
// ============================================================================
// tdct_kw_match: keyword detector
// Compares the token length and leading characters against the keyword list.
// ============================================================================
`default_nettype none

module tdct_kw_match (
   input  wire logic [tdct_pkg::CNT_W-1:0]                                 count,
   input  wire logic [tdct_pkg::WORD_BUF_DEPTH-1:0][tdct_pkg::CHAR_W-1:0]  word,
   output logic                                                            hit
);
   import tdct_pkg::*;

   always_comb begin
      logic match;
      hit = 1'b0;
      for (int k = 0; k < KW_NUM; k++) begin
         match = (32'(count) == 32'(KW_LEN[k]));
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < int'(KW_LEN[k])) begin
               if (word[i] != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) begin
                  match = 1'b0;
               end
            end
         end
         hit = hit | match;
      end
   end

endmodule

`default_nettype wire

/* rtl/tdct_scan.sv */
// ============================================================================
// tdct_scan: character classifier and scan state machine
// Steps the state table once per item and forms up to two token results.
// ============================================================================
`default_nettype none

module tdct_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [tdct_pkg::CHAR_W-1:0]   char_code,
   input  wire logic                          line_end,
   output tdct_pkg::scan_out_type             scan_out
);
   import tdct_pkg::*;

   function automatic scan_state_type char_class(input logic [CHAR_W-1:0] c);
      scan_state_type col;
      if (c == 8'h21) begin                                   // '!'
         col = S_CMT;
      end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
         col = S_SPACE;
      end else if (c >= 8'h30 && c <= 8'h39) begin            // digits
         col = S_INT;
      end else if (c == 8'h2E) begin                          // '.'
         col = S_REAL;
      end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                   c == 8'h24) begin                          // letters, '$'
         col = S_WORD;
      end else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
                   c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h25) begin
         col = S_OP;
      end else if (c >= 8'h21 && c <= 8'h7E) begin
         col = S_SEP;
      end else begin
         col = S_UNK;
      end
      return col;
   endfunction

   function automatic scan_state_type next_tab(input scan_state_type s,
                                               input scan_state_type col);
      scan_state_type nx;
      case (s)
         S_INT: begin
            nx = (col == S_INT || col == S_REAL || col == S_WORD || col == S_CMT) ?
                 col : S_IDLE;
         end
         S_REAL: begin
            if (col == S_INT)       nx = S_REAL;
            else if (col == S_REAL) nx = S_UNK;   // second '.' sticks in unknown
            else if (col == S_CMT)  nx = S_CMT;
            else                    nx = S_IDLE;
         end
         S_WORD: begin
            if (col == S_INT || col == S_WORD) nx = S_WORD;
            else if (col == S_CMT)             nx = S_CMT;
            else                               nx = S_IDLE;
         end
         S_OP, S_SPACE, S_SEP: begin
            nx = (col == S_CMT) ? S_CMT : S_IDLE;
         end
         S_CMT: begin
            nx = (col == S_CMT) ? S_IDLE : S_CMT;
         end
         S_UNK: begin
            nx = S_UNK;
         end
         default: begin
            nx = col;
         end
      endcase
      return nx;
   endfunction

   function automatic kind_type kind_of(input scan_state_type s, input logic kw);
      kind_type k;
      case (s)
         S_INT:   k = KIND_INT;
         S_REAL:  k = KIND_REAL;
         S_OP:    k = KIND_OP;
         S_WORD:  k = kw ? KIND_KW : KIND_ID;
         S_SEP:   k = KIND_SEP;
         default: k = KIND_UNK;
      endcase
      return k;
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] n);
      return (32'(n) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(n);
   endfunction

   function automatic logic opens_token(input scan_state_type s);
      return !(s == S_IDLE || s == S_SPACE || s == S_CMT);
   endfunction

   scan_state_type                          state_ff, state_in, state_mid, col, nx;
   logic                                    cmt_ff, cmt_in, cmt_mid;
   logic [CNT_W-1:0]                        count_ff, count_in, count_mid, count_inc;
   logic [WORD_BUF_DEPTH-1:0][CHAR_W-1:0]   word_ff, word_mid;
   logic                                    wr_en;
   logic [WBI_W-1:0]                        wr_idx;
   logic                                    close, end1, emit1, emit2;
   logic                                    kw_cur, kw_mid;

   assign count_inc = (32'(count_ff) < MAX_TOKEN_LEN) ? count_ff + 1'b1 : count_ff;

   // Next state: table step, possible restart of the ending character, line end
   always_comb begin
      col       = char_class(char_code);
      close     = (col == S_CMT) && cmt_ff;
      nx        = next_tab(state_ff, col);
      if (col != S_CMT && cmt_ff) begin
         nx = S_CMT;
      end
      end1      = !close && (nx == S_IDLE);
      emit1     = end1 && opens_token(state_ff);
      wr_en     = 1'b0;
      wr_idx    = count_ff[WBI_W-1:0];
      state_mid = S_IDLE;
      count_mid = '0;
      cmt_mid   = cmt_ff;
      if (close) begin
         // closing '!': consumed, except that an unknown token absorbs it
         cmt_mid = 1'b0;
         if (state_ff == S_UNK) begin
            state_mid = S_UNK;
            count_mid = count_inc;
            wr_en     = (32'(count_ff) < WORD_BUF_DEPTH);
         end
      end else if (!end1) begin
         cmt_mid   = (col == S_CMT) ? 1'b1 : cmt_ff;
         state_mid = nx;
         count_mid = count_inc;
         wr_en     = (32'(count_ff) < WORD_BUF_DEPTH);
      end else if (col == S_CMT) begin
         // comment state left by '!' with flag clear: rerun closes at once
         cmt_mid = 1'b0;
      end else begin
         // character ended the token; it starts a new one from idle
         state_mid = cmt_ff ? S_CMT : col;
         count_mid = CNT_W'(1);
         wr_en     = 1'b1;
         wr_idx    = '0;
      end

      word_mid = word_ff;
      if (wr_en) begin
         word_mid[wr_idx] = char_code;
      end

      emit2    = line_end && opens_token(state_mid);
      state_in = line_end ? S_IDLE : state_mid;
      count_in = line_end ? '0 : count_mid;
      cmt_in   = cmt_mid;
   end

   tdct_kw_match u_kw_cur (
      .count (count_ff),
      .word  (word_ff),
      .hit   (kw_cur)
   );

   tdct_kw_match u_kw_mid (
      .count (count_mid),
      .word  (word_mid),
      .hit   (kw_mid)
   );

   // Outputs
   always_comb begin
      scan_out.num         = {1'b0, emit1} + {1'b0, emit2};
      scan_out.res1.kind   = kind_of(state_mid, kw_mid);
      scan_out.res1.length = sat_len(count_mid);
      scan_out.res1.last   = 1'b1;
      if (emit1) begin
         scan_out.res0.kind   = kind_of(state_ff, kw_cur);
         scan_out.res0.length = sat_len(count_ff);
         scan_out.res0.last   = !emit2;
      end else begin
         scan_out.res0 = scan_out.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmt_ff   <= 1'b0;
         count_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         cmt_ff   <= cmt_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         word_ff[wr_idx] <= char_code;
      end
   end

endmodule

`default_nettype wire

/* rtl/tdct_rsp_queue.sv */
// ============================================================================
// tdct_rsp_queue: result queue
// Takes zero to two results per cycle, hands out one per cycle while head_ready is high.
// ============================================================================
`default_nettype none

module tdct_rsp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire tdct_pkg::scan_out_type  push_data,
   output logic                         room,
   output logic                         head_valid,
   input  wire logic                    head_ready,
   output tdct_pkg::result_type         head
);
   import tdct_pkg::*;

   result_type            mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   fill_ff, fill_in, push_num;
   logic                  pop;

   assign room       = (32'(fill_ff) + 2 <= RQ_DEPTH);
   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign pop        = head_valid && head_ready;
   assign push_num   = push ? RQ_CNT_W'(push_data.num) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push_num);
      rd_ptr_in = rd_ptr_ff + RQ_PTR_W'(pop);
      fill_in   = fill_ff + push_num - RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_data.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.res0;
      end
      if (push && push_data.num == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= push_data.res1;
      end
   end

endmodule

`default_nettype wire
